// File: src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Property checked only while reset is released.
`define ASSERT_RESET(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

// File: src/hstc_pkg.sv
// ----------------------------------------------------------------------------
// hstc_pkg
// Types and constants shared by the terrain colour ramp modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hstc_pkg;

  localparam int MAX_LEVELS   = 8;
  localparam int LVL_W        = $clog2(MAX_LEVELS);
  localparam int CNT_W        = $clog2(MAX_LEVELS + 1);
  localparam int MIN_LEVELS   = 2;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam int HEIGHT_W     = 16;
  localparam int COLOUR_W     = 24;
  localparam int CHAN_W       = 8;
  localparam int SLOPE_W      = 8;
  localparam int FRAC_W       = 8;
  localparam int PIX_W        = 20;
  localparam int ENTRY_IDX_W  = 3;
  localparam int NUM_LEVELS_W = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SLOPE_W-1:0]      SLOPE_THRESHOLD = 8'd13;
  localparam logic [NUM_LEVELS_W-1:0] NUM_LEVELS_RST  = 4'd4;
  localparam logic [HEIGHT_W-1:0]     MAX_HEIGHT_RST  = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 1'b1;

  typedef enum logic {
    KIND_LOAD,
    KIND_PIXEL
  } item_kind_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    item_kind_e               kind;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic [HEIGHT_W-1:0]      height;
    logic [COLOUR_W-1:0]      colour;
    logic [SLOPE_W-1:0]       slope;
    logic [PIX_W-1:0]         pix;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_LO_RD,
    ST_LO_CHK,
    ST_DIV,
    ST_COL,
    ST_MIX,
    ST_SLOPE
  } back_state_e;

endpackage

`default_nettype wire

// File: src/hstc_front.sv
// ----------------------------------------------------------------------------
// hstc_front
// Accepts items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hstc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode_i,
  input  wire logic [hstc_pkg::ENTRY_IDX_W-1:0] entry_index_i,
  input  wire logic [hstc_pkg::HEIGHT_W-1:0] entry_height_i,
  input  wire logic [hstc_pkg::CHAN_W-1:0]   entry_red_i,
  input  wire logic [hstc_pkg::CHAN_W-1:0]   entry_green_i,
  input  wire logic [hstc_pkg::CHAN_W-1:0]   entry_blue_i,
  input  wire logic [hstc_pkg::HEIGHT_W-1:0] sample_height_i,
  input  wire logic [hstc_pkg::SLOPE_W-1:0]  sample_slope_i,
  input  wire logic [hstc_pkg::PIX_W-1:0]    pixel_index_i,
  input  hstc_pkg::q_status_t                q_status_i,
  output logic                               push_o,
  output hstc_pkg::item_t                    push_item_o
);
  import hstc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;
  logic  in_range;

  assign busy        = valid_q && q_status_i.full;
  assign accept      = start && !busy;
  assign push_o      = valid_q && !q_status_i.full;
  assign push_item_o = item_q;

  // A load aimed beyond the table is taken and then dropped.
  assign in_range = int'(entry_index_i) < MAX_LEVELS;

  assign valid_d = (accept && (mode_i || in_range)) || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind        <= mode_i ? KIND_PIXEL : KIND_LOAD;
      item_q.entry_index <= entry_index_i;
      item_q.height      <= mode_i ? sample_height_i : entry_height_i;
      item_q.colour      <= {entry_red_i, entry_green_i, entry_blue_i};
      item_q.slope       <= sample_slope_i;
      item_q.pix         <= pixel_index_i;
    end
  end

endmodule

`default_nettype wire

// File: src/hstc_queue.sv
// ----------------------------------------------------------------------------
// hstc_queue
// Short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
`default_nettype none

module hstc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  hstc_pkg::item_t    push_item_i,
  input  wire logic          pop_i,
  output hstc_pkg::item_t    pop_item_o,
  output hstc_pkg::q_status_t status_o
);
  import hstc_pkg::*;

  item_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign status_o.full  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign status_o.empty = count_q == '0;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_item_o     = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: src/hstc_back.sv
// ----------------------------------------------------------------------------
// hstc_back
// Level table, band search, fraction divider and colour blending sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module hstc_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  hstc_pkg::q_status_t                    q_status_i,
  input  hstc_pkg::item_t                        pop_item_i,
  output logic                                   pop_o,
  input  wire logic [hstc_pkg::NUM_LEVELS_W-1:0] num_levels_i,
  input  wire logic [hstc_pkg::HEIGHT_W-1:0]     max_height_i,
  output logic                                   out_valid_o,
  output logic [hstc_pkg::PIX_W-1:0]             out_index_o,
  output logic [hstc_pkg::CHAN_W-1:0]            out_red_o,
  output logic [hstc_pkg::CHAN_W-1:0]            out_green_o,
  output logic [hstc_pkg::CHAN_W-1:0]            out_blue_o
);
  import hstc_pkg::*;

  localparam int ENTRY_W = HEIGHT_W + COLOUR_W;

  function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOUR_W-1:0] c,
                                                input logic [1:0] sel);
    unique case (sel)
      2'd0:    return c[23:16];
      2'd1:    return c[15:8];
      default: return c[7:0];
    endcase
  endfunction

  // Level table: height in the upper bits, colour in the lower.
  logic [ENTRY_W-1:0] table_mem [MAX_LEVELS];
  logic [ENTRY_W-1:0] rdata_q;
  logic [LVL_W-1:0]   rd_addr;
  logic               mem_we;

  back_state_e        state_q, state_d;
  logic [CNT_W-1:0]   up_q, up_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  logic [LVL_W-1:0]    lo_idx_q, lo_idx_d, hi_idx_q, hi_idx_d;
  logic [HEIGHT_W-1:0] h_q, h_d, hi_h_q, hi_h_d;
  logic [HEIGHT_W-1:0] rem_q, rem_d, span_q, span_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [SLOPE_W-1:0]  slope_q, slope_d;
  logic [PIX_W-1:0]    pix_q, pix_d;
  logic [COLOUR_W-1:0] clo_q, clo_d, chi_q, chi_d, c2_q, c2_d;
  logic [15:0]         mix_q, mix_d;
  logic [CHAN_W-1:0]   red_q, red_d, green_q, green_d, blue_q, blue_d;

  logic [CNT_W-1:0]    n_sat;
  logic [HEIGHT_W-1:0] rh, h_eff;
  logic [HEIGHT_W:0]   r2;
  logic [CHAN_W-1:0]   ch_lo, ch_hi, ch_2, res_ch;
  logic [8:0]          w_lo, inv;
  logic [16:0]         mix_full;
  logic [23:0]         blend;

  // Level count saturated into the usable range.
  always_comb begin
    if (int'(num_levels_i) < MIN_LEVELS) begin
      n_sat = CNT_W'(MIN_LEVELS);
    end else if (int'(num_levels_i) > MAX_LEVELS) begin
      n_sat = CNT_W'(MAX_LEVELS);
    end else begin
      n_sat = CNT_W'(num_levels_i);
    end
  end

  assign rh    = rdata_q[ENTRY_W-1:COLOUR_W];
  assign h_eff = ((up_q == n_q - CNT_W'(1)) && (rh == '0)) ? max_height_i : rh;
  assign r2    = {rem_q, 1'b0};

  assign ch_lo    = chan_of(clo_q, cnt_q[1:0]);
  assign ch_hi    = chan_of(chi_q, cnt_q[1:0]);
  assign ch_2     = chan_of(c2_q, cnt_q[1:0]);
  assign w_lo     = 9'd256 - {1'b0, frac_q};
  assign mix_full = (17'(ch_lo) * 17'(w_lo)) + (17'(ch_hi) * 17'(frac_q));
  assign inv      = 9'd256 - {1'b0, slope_q};
  assign blend    = (24'(mix_q) * 24'(inv)) + {16'(ch_2) * 16'(slope_q), 8'd0};
  assign res_ch   = (slope_q < SLOPE_THRESHOLD) ? mix_q[15:8] : blend[23:16];

  always_comb begin
    state_d     = state_q;
    up_d        = up_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    out_valid_d = 1'b0;
    lo_idx_d    = lo_idx_q;
    hi_idx_d    = hi_idx_q;
    h_d         = h_q;
    hi_h_d      = hi_h_q;
    rem_d       = rem_q;
    span_d      = span_q;
    frac_d      = frac_q;
    slope_d     = slope_q;
    pix_d       = pix_q;
    clo_d       = clo_q;
    chi_d       = chi_q;
    c2_d        = c2_q;
    mix_d       = mix_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = up_q[LVL_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          if (pop_item_i.kind == KIND_LOAD) begin
            mem_we = 1'b1;
          end else begin
            h_d     = pop_item_i.height;
            slope_d = pop_item_i.slope;
            pix_d   = pop_item_i.pix;
            n_d     = n_sat;
            up_d    = CNT_W'(1);
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: begin
        state_d = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (h_q >= h_eff) begin
          if (up_q + CNT_W'(1) == n_q) begin
            // Above the top level: both ends are the top entry.
            lo_idx_d = LVL_W'(n_q - CNT_W'(1));
            hi_idx_d = LVL_W'(n_q - CNT_W'(1));
            frac_d   = '0;
            cnt_d    = '0;
            state_d  = ST_COL;
          end else begin
            up_d    = up_q + CNT_W'(1);
            state_d = ST_SRCH_RD;
          end
        end else begin
          hi_h_d   = h_eff;
          lo_idx_d = LVL_W'(up_q - CNT_W'(1));
          hi_idx_d = up_q[LVL_W-1:0];
          state_d  = ST_LO_RD;
        end
      end
      ST_LO_RD: begin
        rd_addr = lo_idx_q;
        state_d = ST_LO_CHK;
      end
      ST_LO_CHK: begin
        frac_d = '0;
        cnt_d  = '0;
        if ((hi_h_q > rh) && (h_q >= rh)) begin
          rem_d   = h_q - rh;
          span_d  = hi_h_q - rh;
          state_d = ST_DIV;
        end else begin
          state_d = ST_COL;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; the remainder stays below the span.
        if (r2 >= {1'b0, span_q}) begin
          rem_d  = HEIGHT_W'(r2 - {1'b0, span_q});
          frac_d = {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          rem_d  = r2[HEIGHT_W-1:0];
          frac_d = {frac_q[FRAC_W-2:0], 1'b0};
        end
        if (cnt_q == 3'(FRAC_W - 1)) begin
          cnt_d   = '0;
          state_d = ST_COL;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_COL: begin
        // Fetch the low, high and slope colours; read data arrives the cycle after its address.
        unique case (cnt_q)
          3'd0:    rd_addr = lo_idx_q;
          3'd1:    rd_addr = hi_idx_q;
          default: rd_addr = LVL_W'(2);
        endcase
        if (cnt_q == 3'd1) begin
          clo_d = rdata_q[COLOUR_W-1:0];
        end
        if (cnt_q == 3'd2) begin
          chi_d = rdata_q[COLOUR_W-1:0];
        end
        if (cnt_q == 3'd3) begin
          c2_d    = rdata_q[COLOUR_W-1:0];
          cnt_d   = '0;
          state_d = ST_MIX;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_MIX: begin
        mix_d   = mix_full[15:0];
        state_d = ST_SLOPE;
      end
      ST_SLOPE: begin
        unique case (cnt_q)
          3'd0:    red_d   = res_ch;
          3'd1:    green_d = res_ch;
          default: blue_d  = res_ch;
        endcase
        if (cnt_q == 3'd2) begin
          cnt_d       = '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 3'd1;
          state_d = ST_MIX;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      up_q        <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      up_q        <= up_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_idx_q <= lo_idx_d;
    hi_idx_q <= hi_idx_d;
    h_q      <= h_d;
    hi_h_q   <= hi_h_d;
    rem_q    <= rem_d;
    span_q   <= span_d;
    frac_q   <= frac_d;
    slope_q  <= slope_d;
    pix_q    <= pix_d;
    clo_q    <= clo_d;
    chi_q    <= chi_d;
    c2_q     <= c2_d;
    mix_q    <= mix_d;
    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[LVL_W'(pop_item_i.entry_index)] <= {pop_item_i.height, pop_item_i.colour};
    end
    rdata_q <= table_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = pix_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;

endmodule

`default_nettype wire

// File: src/height_slope_terrain_colour.sv
// ----------------------------------------------------------------------------
// height_slope_terrain_colour
// Height based colour ramp for terrain pixels, with a slope blend.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. A
// load item (mode 0) writes one entry of the level table and gives no result.
// A pixel item (mode 1) gives exactly one result, shown for a single cycle
// with out_valid_o high; the receiver cannot hold it off, so none is dropped.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i while no item is in flight.
// The front registers an item and passes it to a two-entry queue, so up to
// three items may wait while the back works. The back serves one item at a
// time: a load writes one table entry; a pixel's time in the back is set by
// the serial band search (a read and a check per level passed, one table read
// port), an eight-bit radix-2 divider for the fraction, three colour reads
// and a mix and a slope step per colour channel.
// Reset clears the queue and sequencer and restores the level count to four
// and the maximum height to its top value; the level table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module height_slope_terrain_colour (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cfg_we_i,
  input  wire logic [hstc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [hstc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              mode_i,
  input  wire logic [hstc_pkg::ENTRY_IDX_W-1:0]  entry_index_i,
  input  wire logic [hstc_pkg::HEIGHT_W-1:0]     entry_height_i,
  input  wire logic [hstc_pkg::CHAN_W-1:0]       entry_red_i,
  input  wire logic [hstc_pkg::CHAN_W-1:0]       entry_green_i,
  input  wire logic [hstc_pkg::CHAN_W-1:0]       entry_blue_i,
  input  wire logic [hstc_pkg::HEIGHT_W-1:0]     sample_height_i,
  input  wire logic [hstc_pkg::SLOPE_W-1:0]      sample_slope_i,
  input  wire logic [hstc_pkg::PIX_W-1:0]        pixel_index_i,
  output logic                                   out_valid_o,
  output logic [hstc_pkg::PIX_W-1:0]             out_index_o,
  output logic [hstc_pkg::CHAN_W-1:0]            out_red_o,
  output logic [hstc_pkg::CHAN_W-1:0]            out_green_o,
  output logic [hstc_pkg::CHAN_W-1:0]            out_blue_o
);
  import hstc_pkg::*;

  // Configuration registers. The back reads them live, which is safe only if
  // the user changes them while the block is idle; the block does not enforce it.
  logic [NUM_LEVELS_W-1:0] num_levels_q;
  logic [HEIGHT_W-1:0]     max_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= NUM_LEVELS_RST;
      max_height_q <= MAX_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_LEVELS: num_levels_q <= cfg_wdata_i[NUM_LEVELS_W-1:0];
        CFG_MAX_HEIGHT: max_height_q <= cfg_wdata_i[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hand-off between the front and the back.
  logic      push, pop;
  item_t     push_item, pop_item;
  q_status_t q_status;

  hstc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .entry_index_i   (entry_index_i),
    .entry_height_i  (entry_height_i),
    .entry_red_i     (entry_red_i),
    .entry_green_i   (entry_green_i),
    .entry_blue_i    (entry_blue_i),
    .sample_height_i (sample_height_i),
    .sample_slope_i  (sample_slope_i),
    .pixel_index_i   (pixel_index_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  hstc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  // The back owns the level table, so loads and pixels keep their order.
  hstc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .pop_item_i   (pop_item),
    .pop_o        (pop),
    .num_levels_i (num_levels_q),
    .max_height_i (max_height_q),
    .out_valid_o  (out_valid_o),
    .out_index_o  (out_index_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o)
  );

endmodule

`default_nettype wire

// File: src/hstc_checker.sv
// ----------------------------------------------------------------------------
// hstc_checker
// Port level checks of the terrain colour ramp, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hstc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid_o
);

  // Every pixel needs many cycles, so strobes never come back to back.
  `ASSERT_RESET(a_no_double_strobe, clk_i, rst_ni, out_valid_o |=> !out_valid_o)

  // No result follows an edge at which reset was held.
  `ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |=> !out_valid_o)

  // The block only fills up as a result of taking an item.
  `ASSERT_RESET(a_busy_after_accept, clk_i, rst_ni, $rose(busy) |-> $past(start && !busy))

endmodule

bind height_slope_terrain_colour hstc_checker u_hstc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_valid_o (out_valid_o)
);

`default_nettype wire
